FILE: hdl/pwmc_pkg.sv
// ============================================================================
// pwmc_pkg - shared types and constants for the PWM prescaler calculator
// Timer clock, clamp limits, prescaler codes, the queued command layout and
// the reciprocal used for the divide by one thousand.
// ============================================================================
`default_nettype none

package pwmc_pkg;

    // Timer clock and input clamp limits
    localparam logic [23:0] CLK_HZ   = 24'd16000000;
    localparam logic [23:0] FREQ_MAX = 24'd16000000;
    localparam logic [9:0]  DUTY_MAX = 10'd1000;
    localparam logic [15:0] TOP_MAX  = 16'hFFFF;

    // Smallest f per prescaler p that fits the 16-bit counter: 65536*p*f >= 16 MHz
    localparam logic [23:0] FIT_P1  = 24'd245;
    localparam logic [23:0] FIT_P8  = 24'd31;
    localparam logic [23:0] FIT_P64 = 24'd4;
    localparam logic [23:0] FIT_P256 = 24'd1;

    // Clock select codes
    localparam logic [2:0] SEL_OFF   = 3'd0;
    localparam logic [2:0] SEL_P1    = 3'd1;
    localparam logic [2:0] SEL_P8    = 3'd2;
    localparam logic [2:0] SEL_P64   = 3'd3;
    localparam logic [2:0] SEL_P256  = 3'd4;
    localparam logic [2:0] SEL_P1024 = 3'd5;

    // Quotient bits: 16 MHz / 245 stays below 2^16
    localparam int QUO_BITS = 16;

    // floor(x/1000) = (x * ceil(2^36/1000)) >> 36 for x below 2^26.
    // The 27-bit multiplier is split in two halves at bit 14.
    localparam int          RECIP_SHIFT = 36;
    localparam logic [12:0] RECIP_HI    = 13'd4194;
    localparam logic [13:0] RECIP_LO    = 14'd4981;

    // Classified command handed from the front end to the back end
    typedef struct packed {
        logic [2:0]  sel;
        logic [23:0] divisor;
        logic [9:0]  duty;
    } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/pwm_prescaler_top_calculator_core.sv
// ============================================================================
// pwm_prescaler_top_calculator_core - PWM timer setting calculator
// Turns a wanted frequency, duty and enable into clock select, counter top
// and compare value for a 16-bit timer running from a 16 MHz clock.
// ============================================================================
//
// Usage
//   An item (freq_hz, duty_tenths, enable) is taken at a rising edge where
//   start is high and busy is low. Each item gives exactly one result on
//   clock_select, period_top and compare_value, shown for one cycle with
//   done high; results come out in the order the items went in.
//   The result passes the front register, a queue slot, 16 divider stages,
//   top, multiply and two reciprocal stages before it reaches the ports.
//   The divider resolves one quotient bit per stage.
//   Throughput: one item per cycle; the pipeline is fully staged, so busy
//   only rises if the queue fills, which does not happen in normal flow.
//   The receiver cannot stall: done is a strobe and must be taken as shown.
//   Reset empties the queue and clears all valid flags; no result is shown
//   until an item has been taken after reset.
//
`default_nettype none

module pwm_prescaler_top_calculator_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [23:0] freq_hz,
    input  wire  [9:0]  duty_tenths,
    input  wire         enable,
    output logic        done,
    output logic [2:0]  clock_select,
    output logic [15:0] period_top,
    output logic [15:0] compare_value
);

    logic           accept;
    logic           front_valid;
    pwmc_pkg::cmd_t front_cmd;
    logic           head_valid;
    pwmc_pkg::cmd_t head_cmd;
    logic           queue_full;
    logic           queue_almost_full;
    logic           back_take;

    // Hold off when the item already in the front register may use the last slot
    assign busy   = queue_full || (queue_almost_full && front_valid);
    assign accept = start && !busy;

    pwmc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .freq_hz     (freq_hz),
        .duty_tenths (duty_tenths),
        .enable      (enable),
        .cmd_valid   (front_valid),
        .cmd         (front_cmd)
    );

    pwmc_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (front_valid),
        .push_cmd    (front_cmd),
        .pop         (back_take),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .full        (queue_full),
        .almost_full (queue_almost_full)
    );

    pwmc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (head_valid),
        .in_cmd        (head_cmd),
        .take          (back_take),
        .done          (done),
        .clock_select  (clock_select),
        .period_top    (period_top),
        .compare_value (compare_value)
    );

endmodule

`default_nettype wire

FILE: hdl/pwmc_front.sv
// ============================================================================
// pwmc_front - input clamp and prescaler selection
// Clamps frequency and duty, picks the first prescaler that fits and forms
// the divisor p*f. Registers one classified command per accepted item.
// ============================================================================
`default_nettype none

module pwmc_front
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 accept,
    input  wire  [23:0]         freq_hz,
    input  wire  [9:0]          duty_tenths,
    input  wire                 enable,
    output logic                cmd_valid,
    output pwmc_pkg::cmd_t      cmd
);

    logic [23:0]    freq_c;
    logic [9:0]     duty_c;
    pwmc_pkg::cmd_t cmd_next;
    logic           valid_reg;
    pwmc_pkg::cmd_t cmd_reg;

    // Saturate the inputs
    always_comb
    begin
        freq_c = (freq_hz > pwmc_pkg::FREQ_MAX) ? pwmc_pkg::FREQ_MAX : freq_hz;
        duty_c = (duty_tenths > pwmc_pkg::DUTY_MAX) ? pwmc_pkg::DUTY_MAX : duty_tenths;
    end

    // First fitting prescaler; a shift forms p*f since p is a power of two
    always_comb
    begin
        cmd_next.duty = duty_c;
        priority if (!enable)
        begin
            cmd_next.sel     = pwmc_pkg::SEL_OFF;
            cmd_next.divisor = 24'd1;
        end
        else if (freq_c >= pwmc_pkg::FIT_P1)
        begin
            cmd_next.sel     = pwmc_pkg::SEL_P1;
            cmd_next.divisor = freq_c;
        end
        else if (freq_c >= pwmc_pkg::FIT_P8)
        begin
            cmd_next.sel     = pwmc_pkg::SEL_P8;
            cmd_next.divisor = {freq_c[20:0], 3'b000};
        end
        else if (freq_c >= pwmc_pkg::FIT_P64)
        begin
            cmd_next.sel     = pwmc_pkg::SEL_P64;
            cmd_next.divisor = {freq_c[17:0], 6'b000000};
        end
        else if (freq_c >= pwmc_pkg::FIT_P256)
        begin
            cmd_next.sel     = pwmc_pkg::SEL_P256;
            cmd_next.divisor = {freq_c[15:0], 8'h00};
        end
        else
        begin
            // zero frequency: nothing fits, slowest prescaler at full count
            cmd_next.sel     = pwmc_pkg::SEL_P1024;
            cmd_next.divisor = 24'd1;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

FILE: hdl/pwmc_queue.sv
// ============================================================================
// pwmc_queue - short command queue between front and back end
// Circular buffer of classified items with a fill count. Flags tell the
// top level when the next accepted item might not find room.
// ============================================================================
`default_nettype none

module pwmc_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  wire pwmc_pkg::cmd_t push_cmd,
    input  wire                 pop,
    output logic                head_valid,
    output pwmc_pkg::cmd_t      head_cmd,
    output logic                full,
    output logic                almost_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    pwmc_pkg::cmd_t     store_reg [0:DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_pop;

    assign do_pop = pop && (count_reg != '0);

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_valid  = (count_reg != '0);
    assign head_cmd    = store_reg[rd_ptr_reg];
    assign full        = (count_reg == CNT_W'(DEPTH));
    assign almost_full = (count_reg >= CNT_W'(DEPTH - 1));

endmodule

`default_nettype wire

FILE: hdl/pwmc_back.sv
// ============================================================================
// pwmc_back - period and compare pipeline
// Restoring divider, one quotient bit per stage, gives 16 MHz / (p*f).
// Then top = quotient - 1, a duty multiply and a reciprocal divide by 1000.
// Takes one item per cycle and never stalls.
// ============================================================================
`default_nettype none

module pwmc_back
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire pwmc_pkg::cmd_t in_cmd,
    output logic                take,
    output logic                done,
    output logic [2:0]          clock_select,
    output logic [15:0]         period_top,
    output logic [15:0]         compare_value
);

    localparam int QB = pwmc_pkg::QUO_BITS;

    // Divider stage registers; index 0 is the stage input, QB the result
    logic           st_valid_reg [0:QB];
    logic [23:0]    st_rem_reg   [0:QB];
    logic [23:0]    st_div_reg   [0:QB];
    logic [QB-1:0]  st_quo_reg   [0:QB];
    logic [2:0]     st_sel_reg   [0:QB];
    logic [9:0]     st_duty_reg  [0:QB];

    logic [23:0]    st_rem_next  [0:QB-1];
    logic [QB-1:0]  st_quo_next  [0:QB-1];

    // Top stage
    logic           t_valid_reg;
    logic [2:0]     t_sel_reg;
    logic [15:0]    t_top_reg;
    logic [9:0]     t_duty_reg;
    logic [15:0]    t_top_next;

    // Multiply stage
    logic           m_valid_reg;
    logic [2:0]     m_sel_reg;
    logic [15:0]    m_top_reg;
    logic [25:0]    m_prod_reg;

    // Reciprocal partial products
    logic           r_valid_reg;
    logic [2:0]     r_sel_reg;
    logic [15:0]    r_top_reg;
    logic [38:0]    r_pp_hi_reg;
    logic [39:0]    r_pp_lo_reg;
    logic [53:0]    r_sum;

    // Output registers
    logic           o_valid_reg;
    logic [2:0]     o_sel_reg;
    logic [15:0]    o_top_reg;
    logic [15:0]    o_cmp_reg;

    assign take = in_valid;

    // One trial subtraction per stage against divisor << bit
    always_comb
    begin
        for (int i = 0; i < QB; i++)
        begin
            logic [39:0] shifted;
            logic        ge;
            shifted = {16'b0, st_div_reg[i]} << (QB - 1 - i);
            ge      = ({16'b0, st_rem_reg[i]} >= shifted);
            st_rem_next[i] = ge ? (st_rem_reg[i] - shifted[23:0]) : st_rem_reg[i];
            st_quo_next[i] = {st_quo_reg[i][QB-2:0], ge};
        end
    end

    // Divider control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QB; i++)
            begin
                st_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            st_valid_reg[0] <= in_valid;
            for (int i = 0; i < QB; i++)
            begin
                st_valid_reg[i+1] <= st_valid_reg[i];
            end
        end
    end

    // Divider payload
    always_ff @(posedge clk)
    begin
        st_rem_reg[0]  <= pwmc_pkg::CLK_HZ;
        st_div_reg[0]  <= in_cmd.divisor;
        st_quo_reg[0]  <= '0;
        st_sel_reg[0]  <= in_cmd.sel;
        st_duty_reg[0] <= in_cmd.duty;
        for (int i = 0; i < QB; i++)
        begin
            st_rem_reg[i+1]  <= st_rem_next[i];
            st_div_reg[i+1]  <= st_div_reg[i];
            st_quo_reg[i+1]  <= st_quo_next[i];
            st_sel_reg[i+1]  <= st_sel_reg[i];
            st_duty_reg[i+1] <= st_duty_reg[i];
        end
    end

    // Counter top: stopped reads zero, no fit reads full count
    always_comb
    begin
        priority if (st_sel_reg[QB] == pwmc_pkg::SEL_OFF)
        begin
            t_top_next = 16'd0;
        end
        else if (st_sel_reg[QB] == pwmc_pkg::SEL_P1024)
        begin
            t_top_next = pwmc_pkg::TOP_MAX;
        end
        else
        begin
            t_top_next = st_quo_reg[QB] - 1'b1;
        end
    end

    // Sum of the two reciprocal partial products
    assign r_sum = {1'b0, r_pp_hi_reg, 14'b0} + {14'b0, r_pp_lo_reg};

    // Tail control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            t_valid_reg <= st_valid_reg[QB];
            m_valid_reg <= t_valid_reg;
            r_valid_reg <= m_valid_reg;
            o_valid_reg <= r_valid_reg;
        end
    end

    // Tail payload
    always_ff @(posedge clk)
    begin
        t_sel_reg   <= st_sel_reg[QB];
        t_top_reg   <= t_top_next;
        t_duty_reg  <= st_duty_reg[QB];

        m_sel_reg   <= t_sel_reg;
        m_top_reg   <= t_top_reg;
        m_prod_reg  <= {10'b0, t_top_reg} * {16'b0, t_duty_reg};

        r_sel_reg   <= m_sel_reg;
        r_top_reg   <= m_top_reg;
        r_pp_hi_reg <= {13'b0, m_prod_reg} * {26'b0, pwmc_pkg::RECIP_HI};
        r_pp_lo_reg <= {14'b0, m_prod_reg} * {26'b0, pwmc_pkg::RECIP_LO};

        o_sel_reg   <= r_sel_reg;
        o_top_reg   <= r_top_reg;
        o_cmp_reg   <= r_sum[pwmc_pkg::RECIP_SHIFT +: 16];
    end

    assign done          = o_valid_reg;
    assign clock_select  = o_sel_reg;
    assign period_top    = o_top_reg;
    assign compare_value = o_cmp_reg;

endmodule

`default_nettype wire

FILE: hdl/pwmc_checker.sv
// ============================================================================
// pwmc_checker - port level checks for the PWM prescaler calculator
// Watches the result channel for settings that no item can produce, and the busy flag.
// ============================================================================
`default_nettype none

module pwmc_checker
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire         busy,
    input  wire         done,
    input  wire  [2:0]  clock_select,
    input  wire  [15:0] period_top,
    input  wire  [15:0] compare_value
);

    // No result strobe in the cycle straight after reset is released
    a_no_early_done: assert property (@(posedge clk)
        $rose(rst_n) |-> !done)
        else $error("result shown with no item taken");

    // A stopped timer reports zero top and compare
    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clock_select == pwmc_pkg::SEL_OFF) |->
            (period_top == 16'd0 && compare_value == 16'd0))
        else $error("stopped timer with non-zero setting");

    // Slowest prescaler only on the no-fit path, which runs at full count
    a_no_fit_top: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clock_select == pwmc_pkg::SEL_P1024) |->
            period_top == pwmc_pkg::TOP_MAX)
        else $error("no-fit result without full count");

    // Compare never exceeds top and the select code is in range
    a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (compare_value <= period_top && clock_select <= pwmc_pkg::SEL_P1024))
        else $error("result out of range");

    // The queue never holds off an idle input that follows an idle cycle
    a_not_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(start) && !start) |=> !busy)
        else $error("busy raised with no items in flight");

endmodule

bind pwm_prescaler_top_calculator_core pwmc_checker u_pwmc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .clock_select  (clock_select),
    .period_top    (period_top),
    .compare_value (compare_value)
);

`default_nettype wire

FILE: test/pwm_prescaler_top_calculator_core_tb.sv
// ============================================================================
// pwm_prescaler_top_calculator_core_tb - self-checking bench for the PWM
// prescaler calculator
// Items go in through the start/busy handshake. Each one is predicted
// in the bench and the forecast setting is queued. Every done strobe is
// compared field by field against the oldest queued setting. A short table
// of corner items comes first, then 900 random items, most with random gaps.
// ============================================================================
`default_nettype none

module pwm_prescaler_top_calculator_core_tb;

    // One timer setting as shown on the result ports
    typedef struct packed {
        logic [2:0]  sel;
        logic [15:0] top;
        logic [15:0] cmp;
    } pwm_setting_t;

    // One row of the corner table; typed rows carry a hand-written setting
    typedef struct packed {
        logic [23:0]  freq;
        logic [9:0]   duty;
        logic         en;
        logic         typed;
        pwm_setting_t want;
    } corner_row_t;

    localparam int RANDOM_ITEMS = 900;
    localparam int TAIL_CYCLES  = 40;
    localparam int DRAIN_LIMIT  = 5000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [23:0] freq_hz;
    logic [9:0]  duty_tenths;
    logic        enable;
    logic        done;
    logic [2:0]  clock_select;
    logic [15:0] period_top;
    logic [15:0] compare_value;

    pwm_setting_t forecast_settings[$];
    corner_row_t  corner_rows[$];
    int           mismatch_count;
    bit           gaps_on;

    pwm_prescaler_top_calculator_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .freq_hz       (freq_hz),
        .duty_tenths   (duty_tenths),
        .enable        (enable),
        .done          (done),
        .clock_select  (clock_select),
        .period_top    (period_top),
        .compare_value (compare_value)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Timer setting for one item: first prescaler whose span covers the period
    function automatic pwm_setting_t forecast_setting(input logic [23:0] freq,
                                                      input logic [9:0]  duty,
                                                      input logic        en);
        pwm_setting_t    s;
        longint unsigned f_sat;
        longint unsigned d_sat;
        longint unsigned pf;
        longint unsigned top;
        longint unsigned cmp_full;
        logic [2:0]      code;
        int              shift;
        bit              found;
        s = '{pwmc_pkg::SEL_OFF, 16'd0, 16'd0};
        if (en)
        begin
            f_sat = (freq > pwmc_pkg::FREQ_MAX) ? 64'(pwmc_pkg::FREQ_MAX) : 64'(freq);
            d_sat = (duty > pwmc_pkg::DUTY_MAX) ? 64'(pwmc_pkg::DUTY_MAX) : 64'(duty);
            top   = 64'(pwmc_pkg::TOP_MAX);
            s.sel = pwmc_pkg::SEL_P1024;
            found = 1'b0;
            for (int i = 0; i < 5; i++)
            begin
                case (i)
                    0:       begin shift = 0;  code = pwmc_pkg::SEL_P1;    end
                    1:       begin shift = 3;  code = pwmc_pkg::SEL_P8;    end
                    2:       begin shift = 6;  code = pwmc_pkg::SEL_P64;   end
                    3:       begin shift = 8;  code = pwmc_pkg::SEL_P256;  end
                    default: begin shift = 10; code = pwmc_pkg::SEL_P1024; end
                endcase
                pf = f_sat << shift;
                if (!found && pf != 0 && 64'(pwmc_pkg::CLK_HZ) <= 64'd65536 * pf)
                begin
                    top   = 64'(pwmc_pkg::CLK_HZ) / pf - 64'd1;
                    s.sel = code;
                    found = 1'b1;
                end
            end
            cmp_full = (top * d_sat) / 64'd1000;
            s.top    = top[15:0];
            s.cmp    = cmp_full[15:0];
        end
        return s;
    endfunction

    task automatic add_row(input logic [23:0] freq, input logic [9:0] duty,
                           input logic en, input logic typed,
                           input pwm_setting_t want);
        corner_row_t r;
        r.freq  = freq;
        r.duty  = duty;
        r.en    = en;
        r.typed = typed;
        r.want  = want;
        corner_rows.push_back(r);
    endtask

    // Present one item from a falling edge, hold until taken, queue its setting.
    // Random idle cycles follow when gaps are enabled.
    task automatic send_item(input logic [23:0] freq, input logic [9:0] duty,
                             input logic en, input logic typed,
                             input pwm_setting_t want);
        start       = 1'b1;
        freq_hz     = freq;
        duty_tenths = duty;
        enable      = en;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        forecast_settings.push_back(typed ? want : forecast_setting(freq, duty, en));
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 19)
        begin
            start = 1'b0;
            @(negedge clk);
        end
    endtask

    // Hold the sender off until every queued setting has come back
    task automatic hold_until_drained();
        start = 1'b0;
        while (forecast_settings.size() != 0)
            @(negedge clk);
    endtask

    // Result checker: compare every strobed setting with the oldest forecast
    always @(posedge clk)
    begin
        pwm_setting_t exp_s;
        if (rst_n && done === 1'b1)
        begin
            if (forecast_settings.size() == 0)
            begin
                $display("%0t: unexpected result sel %0d top %0d cmp %0d", $time,
                         clock_select, period_top, compare_value);
                mismatch_count++;
            end
            else
            begin
                exp_s = forecast_settings.pop_front();
                if (clock_select !== exp_s.sel)
                begin
                    $display("%0t: clock_select expected %0d actual %0d", $time,
                             exp_s.sel, clock_select);
                    mismatch_count++;
                end
                if (period_top !== exp_s.top)
                begin
                    $display("%0t: period_top expected %0d actual %0d", $time,
                             exp_s.top, period_top);
                    mismatch_count++;
                end
                if (compare_value !== exp_s.cmp)
                begin
                    $display("%0t: compare_value expected %0d actual %0d", $time,
                             exp_s.cmp, compare_value);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [23:0] f;
        logic [9:0]  d;
        logic        en;
        int          pick;
        int          width;
        int          waited;
        mismatch_count = 0;
        gaps_on        = 1'b1;
        rst_n          = 1'b0;
        start          = 1'b0;
        freq_hz        = '0;
        duty_tenths    = '0;
        enable         = 1'b0;

        // Corner table: disabled, zero and saturated frequency, duty clamp,
        // and each boundary where the next prescaler takes over
        add_row(24'd1000,     10'd500,  1'b0, 1'b1, '{pwmc_pkg::SEL_OFF, 16'd0, 16'd0});
        add_row(24'hFFFFFF,   10'h3FF,  1'b0, 1'b1, '{pwmc_pkg::SEL_OFF, 16'd0, 16'd0});
        add_row(24'd0,        10'd0,    1'b1, 1'b1, '{pwmc_pkg::SEL_P1024, 16'hFFFF, 16'd0});
        add_row(24'd0,        10'd1000, 1'b1, 1'b1,
                '{pwmc_pkg::SEL_P1024, 16'hFFFF, 16'hFFFF});
        add_row(24'd0,        10'h3FF,  1'b1, 1'b1,
                '{pwmc_pkg::SEL_P1024, 16'hFFFF, 16'hFFFF});
        add_row(24'd16000000, 10'd1000, 1'b1, 1'b1, '{pwmc_pkg::SEL_P1, 16'd0, 16'd0});
        add_row(24'hFFFFFF,   10'h3FF,  1'b1, 1'b1, '{pwmc_pkg::SEL_P1, 16'd0, 16'd0});
        add_row(24'd16000001, 10'd500,  1'b1, 1'b1, '{pwmc_pkg::SEL_P1, 16'd0, 16'd0});
        add_row(24'd245,      10'd500,  1'b1, 1'b0, '0);
        add_row(24'd244,      10'd500,  1'b1, 1'b0, '0);
        add_row(24'd31,       10'd1000, 1'b1, 1'b0, '0);
        add_row(24'd30,       10'd1,    1'b1, 1'b0, '0);
        add_row(24'd4,        10'd999,  1'b1, 1'b0, '0);
        add_row(24'd3,        10'd250,  1'b1, 1'b0, '0);
        add_row(24'd2,        10'd1000, 1'b1, 1'b0, '0);
        add_row(24'd1,        10'd500,  1'b1, 1'b0, '0);
        add_row(24'd1000,     10'd500,  1'b1, 1'b0, '0);
        add_row(24'd8000000,  10'd1000, 1'b1, 1'b0, '0);
        add_row(24'd15999999, 10'd1000, 1'b1, 1'b0, '0);
        add_row(24'd20000,    10'd0,    1'b1, 1'b0, '0);
        add_row(24'd50,       10'd1001, 1'b1, 1'b0, '0);
        add_row(24'h555555,   10'h2AA,  1'b1, 1'b0, '0);
        add_row(24'hAAAAAA,   10'h155,  1'b1, 1'b0, '0);

        // Hold reset, then release it on a falling edge
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (corner_rows[i])
            send_item(corner_rows[i].freq, corner_rows[i].duty, corner_rows[i].en,
                      corner_rows[i].typed, corner_rows[i].want);
        hold_until_drained();

        // Random items: half log-spread frequencies, some near the
        // prescaler boundaries, some raw 24-bit values
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !(n >= 300 && n < 500);
            if (n == 600)
                hold_until_drained();
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                width = $urandom_range(1, 24);
                f = 24'(($urandom & ((32'd1 << width) - 32'd1)) | (32'd1 << (width - 1)));
            end
            else if (pick < 70)
            begin
                case ($urandom_range(0, 6))
                    0:       f = 24'd245;
                    1:       f = 24'd31;
                    2:       f = 24'd4;
                    3:       f = 24'd1;
                    4:       f = 24'd16000000;
                    5:       f = 24'd8000000;
                    default: f = 24'd0;
                endcase
                f = 24'(f + $urandom_range(0, 4) - 2);
            end
            else
                f = 24'($urandom);

            pick = $urandom_range(0, 99);
            if (pick < 80)
                d = 10'($urandom_range(0, 1000));
            else if (pick < 90)
                d = 10'($urandom_range(1001, 1023));
            else
                d = ($urandom_range(0, 1) != 0) ? 10'd1000 : 10'd0;

            en = ($urandom_range(0, 99) < 90);
            send_item(f, d, en, 1'b0, '0);
        end

        // Drain, then allow the pipeline latency to settle
        start  = 1'b0;
        waited = 0;
        while (forecast_settings.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (forecast_settings.size() != 0)
        begin
            $display("%0t: %0d settings never arrived", $time, forecast_settings.size());
            mismatch_count++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
